// ----- rtl/ktt_pkg.sv -----
// ktt_pkg: shared types, widths and table depth for the key tally table
// no dependencies; compiled before every other file
package ktt_pkg;

  // table geometry
  localparam int DEPTH   = 64;
  localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int FILL_W  = $clog2(DEPTH + 1);

  // field widths
  localparam int KEY_W   = 16;
  localparam int COUNT_W = 16;
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // item operation
  typedef enum logic {
    OP_ADD   = 1'b0,
    OP_FLUSH = 1'b1
  } op_t;

  // classified item held in the queue
  typedef struct packed {
    op_t              op;
    logic [KEY_W-1:0] key;
  } cmd_t;

  // queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } head_t;

  // back end sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

endpackage

// ----- rtl/ktt_in_if.sv -----
// ktt_in_if: input channel carrying one add or flush word
// depends on ktt_pkg for the key width
interface ktt_in_if;
  import ktt_pkg::*;

  logic             valid;
  logic             ready;
  logic             func;
  logic [KEY_W-1:0] key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface

// ----- rtl/ktt_out_if.sv -----
// ktt_out_if: result channel carrying one table entry per word
// depends on ktt_pkg for the key and count widths
interface ktt_out_if;
  import ktt_pkg::*;

  logic               valid;
  logic               ready;
  logic [KEY_W-1:0]   entry_key;
  logic [COUNT_W-1:0] entry_count;
  logic               entry_valid;
  logic               dropped;
  logic               last;

  modport source (output valid, output entry_key, output entry_count,
                  output entry_valid, output dropped, output last, input ready);
  modport sink   (input valid, input entry_key, input entry_count,
                  input entry_valid, input dropped, input last, output ready);
endinterface

// ----- rtl/key_tally_table_core.sv -----
// key_tally_table_core: top level joining the input queue and the table back end
// depends on ktt_pkg, ktt_in_if, ktt_out_if, ktt_front and ktt_back
// queue: an input word is registered into the queue; the back end takes it from the queue head while idle
// add: an empty table appends at once, else a scan walks the stored keys and ends early on a key match
// flush: entry words leave through the output register, one word a cycle while the sink is ready
// empty-table flush: one not-valid word; the scan reads both table memories through one shared read address
// reset: clears queue, fill level, dropped flag and output valid; table memories are not cleared
module key_tally_table_core (
  input  logic      clk,
  input  logic      rst,
  ktt_in_if.sink    items,
  ktt_out_if.source results
);
  import ktt_pkg::*;

  head_t head;
  logic  pop;

  // front end: accept and queue words
  ktt_front u_front (
    .clk   (clk),
    .rst   (rst),
    .items (items),
    .head  (head),
    .pop   (pop)
  );

  // back end: table lookup, update and flush
  ktt_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (head),
    .pop     (pop),
    .results (results)
  );

endmodule

// ----- rtl/ktt_front.sv -----
// ktt_front: accepts input words, classifies them and holds them in a two-entry queue
// depends on ktt_pkg and ktt_in_if
module ktt_front (
  input  logic          clk,
  input  logic          rst,
  ktt_in_if.sink        items,
  output ktt_pkg::head_t head,
  input  logic          pop
);
  import ktt_pkg::*;

  cmd_t       slots [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       take;
  cmd_t       cmd_in;

  // classify the incoming word
  always_comb begin
    cmd_in.op  = items.func ? OP_FLUSH : OP_ADD;
    cmd_in.key = items.key;
  end

  assign items.ready = (count != 2'd2);
  assign push        = items.valid && items.ready;
  assign take        = pop && (count != 2'd0);

  assign head.valid = (count != 2'd0);
  assign head.cmd   = slots[rd_ptr];

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= cmd_in;
    end
  end

  // queue pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (take) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, take};
    end
  end

  // occupancy never goes beyond the two slots
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= 2'd2)
    else $error("queue occupancy out of range");

  // pointers differ exactly when one slot is held
  a_ptr_count: assert property (@(posedge clk) disable iff (rst)
    (wr_ptr != rd_ptr) == (count == 2'd1))
    else $error("queue pointers disagree with occupancy");

endmodule

// ----- rtl/ktt_back.sv -----
// ktt_back: key/count table, sequential lookup and flush sequencer with output register
// depends on ktt_pkg and ktt_out_if
module ktt_back (
  input  logic           clk,
  input  logic           rst,
  input  ktt_pkg::head_t head,
  output logic           pop,
  ktt_out_if.source      results
);
  import ktt_pkg::*;

  // table memories
  logic [KEY_W-1:0]   key_mem   [DEPTH];
  logic [COUNT_W-1:0] count_mem [DEPTH];

  // registers
  state_t             state;
  state_t             state_next;
  logic [FILL_W-1:0]  fill;
  logic [FILL_W-1:0]  fill_next;
  logic               drop;
  logic               drop_next;
  logic [IDX_W-1:0]   rd_idx;
  logic [IDX_W-1:0]   rd_idx_next;
  logic [KEY_W-1:0]   cur_key;
  logic [KEY_W-1:0]   key_q;
  logic [COUNT_W-1:0] count_q;

  // output register
  logic               out_valid;
  logic [KEY_W-1:0]   out_key;
  logic [COUNT_W-1:0] out_count;
  logic               out_entry_valid;
  logic               out_dropped;
  logic               out_last;

  // datapath controls
  logic               out_free;
  logic               rd_last;
  logic               hit;
  logic [IDX_W-1:0]   rd_addr;
  logic               key_we;
  logic [KEY_W-1:0]   key_wd;
  logic               cnt_we;
  logic [IDX_W-1:0]   cnt_wa;
  logic [COUNT_W-1:0] cnt_wd;
  logic [IDX_W-1:0]   app_addr;
  logic               load_out;
  logic               load_empty;
  logic               load_last;

  assign out_free = !out_valid || results.ready;
  assign rd_last  = (FILL_W'(rd_idx) + FILL_W'(1)) == fill;
  assign hit      = (key_q == cur_key);
  assign app_addr = IDX_W'(fill);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (head.valid && (fill != '0)) begin
          state_next = (head.cmd.op == OP_ADD) ? ST_SCAN : ST_FLUSH;
        end
      end
      ST_SCAN: begin
        if (hit || rd_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_FLUSH: begin
        if (out_free && rd_last) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs and table updates
  always_comb begin
    pop         = 1'b0;
    rd_addr     = rd_idx;
    rd_idx_next = rd_idx;
    fill_next   = fill;
    drop_next   = drop;
    key_we      = 1'b0;
    key_wd      = cur_key;
    cnt_we      = 1'b0;
    cnt_wa      = app_addr;
    cnt_wd      = COUNT_W'(1);
    load_out    = 1'b0;
    load_empty  = 1'b0;
    load_last   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.cmd.op == OP_ADD) begin
            pop = 1'b1;
            if (fill == '0) begin
              // empty table: append at once
              key_we    = 1'b1;
              key_wd    = head.cmd.key;
              cnt_we    = 1'b1;
              fill_next = FILL_W'(1);
            end else begin
              rd_addr     = '0;
              rd_idx_next = '0;
            end
          end else if (fill == '0) begin
            // empty flush gives a single not-valid word
            if (out_free) begin
              pop        = 1'b1;
              load_empty = 1'b1;
              drop_next  = 1'b0;
            end
          end else begin
            pop         = 1'b1;
            rd_addr     = '0;
            rd_idx_next = '0;
          end
        end
      end
      ST_SCAN: begin
        if (hit) begin
          cnt_we = 1'b1;
          cnt_wa = rd_idx;
          cnt_wd = (count_q == COUNT_MAX) ? count_q : count_q + COUNT_W'(1);
        end else if (rd_last) begin
          if (fill < FILL_W'(DEPTH)) begin
            key_we    = 1'b1;
            cnt_we    = 1'b1;
            fill_next = fill + FILL_W'(1);
          end else begin
            drop_next = 1'b1;
          end
        end else begin
          rd_addr     = rd_idx + IDX_W'(1);
          rd_idx_next = rd_idx + IDX_W'(1);
        end
      end
      ST_FLUSH: begin
        if (out_free) begin
          load_out = 1'b1;
          if (rd_last) begin
            load_last = 1'b1;
            fill_next = '0;
            drop_next = 1'b0;
          end else begin
            rd_addr     = rd_idx + IDX_W'(1);
            rd_idx_next = rd_idx + IDX_W'(1);
          end
        end
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  // table memories, registered read
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[app_addr] <= key_wd;
    end
    if (cnt_we) begin
      count_mem[cnt_wa] <= cnt_wd;
    end
    key_q   <= key_mem[rd_addr];
    count_q <= count_mem[rd_addr];
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      drop      <= 1'b0;
      rd_idx    <= '0;
      out_valid <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      drop   <= drop_next;
      rd_idx <= rd_idx_next;
      if (load_out || load_empty) begin
        out_valid <= 1'b1;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // add key latch and output word payload
  always_ff @(posedge clk) begin
    if (pop && (head.cmd.op == OP_ADD)) begin
      cur_key <= head.cmd.key;
    end
    if (load_out) begin
      out_key         <= key_q;
      out_count       <= count_q;
      out_entry_valid <= 1'b1;
      out_dropped     <= drop;
      out_last        <= rd_last;
    end else if (load_empty) begin
      out_key         <= '0;
      out_count       <= '0;
      out_entry_valid <= 1'b0;
      out_dropped     <= drop;
      out_last        <= 1'b1;
    end
  end

  assign results.valid       = out_valid;
  assign results.entry_key   = out_key;
  assign results.entry_count = out_count;
  assign results.entry_valid = out_entry_valid;
  assign results.dropped     = out_dropped;
  assign results.last        = out_last;

  // fill level never exceeds the table depth
  a_fill_range: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("fill level beyond table depth");

  // loading the final entry of a flush empties the table and clears the flag
  a_flush_clears: assert property (@(posedge clk) disable iff (rst)
    load_last |=> (fill == '0) && !drop && (state == ST_IDLE))
    else $error("table not cleared after flush");

  // a lookup or flush walk only runs over a non-empty table
  a_walk_nonempty: assert property (@(posedge clk) disable iff (rst)
    (state != ST_IDLE) |-> (fill != '0))
    else $error("table walk over empty table");

endmodule
